[rtl/rv32im_execute_core_assert.svh]
// assertion macros for the execute core
`ifndef RV32IM_EXECUTE_CORE_ASSERT_SVH
`define RV32IM_EXECUTE_CORE_ASSERT_SVH

// same-cycle implication
`define RVX_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rvx check failed");

// next-cycle implication
`define RVX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rvx check failed");

`endif

[rtl/rvx_pkg.sv]
package rvx_pkg;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ECALL   = 3'd1,
    ST_EBREAK  = 3'd2,
    ST_ILLEGAL = 3'd3,
    ST_ORDER   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_LOAD  = 2'd1,
    MEM_STORE = 2'd2
  } mem_op_t;

  localparam logic CFG_START_PC = 1'b0;
  localparam logic CFG_STACK    = 1'b1;

  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_IMM    = 7'h13;
  localparam logic [6:0] OPC_REG    = 7'h33;
  localparam logic [6:0] OPC_FENCE  = 7'h0f;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;
  localparam logic [6:0] F7_MULDIV = 7'b0000001;

  localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

  typedef struct packed {
    logic capture;
    logic mul_go;
    logic div_go;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic div_busy;
  } dp_status_t;

endpackage

[rtl/rv32im_execute_core.sv]
// channel   | handshake               | payload
// in        | in_valid / in_ready     | action, instr_word, load_word
// out       | out_valid / out_ready   | status .. wb_value
// cfg       | cfg_we (no wait)        | cfg_index, cfg_data
//
// one beat at a time: most instructions capture with a register
// file read, then execute and commit; the multiplies add a registered
// product, and divide and remainder add the divider (one quotient bit a cycle).
// a result waits in the output register; the next beat is taken meanwhile
// and held in its execute, multiply or divide state until that register frees.
// reset clears the pc, the pending load and the register valid bits.
module rv32im_execute_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [31:0] instr_word,
  input  logic [31:0] load_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] next_pc,
  output logic [1:0]  mem_op,
  output logic [31:0] mem_addr,
  output logic [1:0]  mem_size,
  output logic [31:0] store_data,
  output logic        wb_enable,
  output logic [4:0]  wb_index,
  output logic [31:0] wb_value,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  `include "rv32im_execute_core_assert.svh"

  rvx_pkg::ctrl_cmd_t  cmd;
  rvx_pkg::dp_status_t st;

  rvx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  rvx_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .action     (action),
    .instr_word (instr_word),
    .load_word  (load_word),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .status     (status),
    .next_pc    (next_pc),
    .mem_op     (mem_op),
    .mem_addr   (mem_addr),
    .mem_size   (mem_size),
    .store_data (store_data),
    .wb_enable  (wb_enable),
    .wb_index   (wb_index),
    .wb_value   (wb_value)
  );

  `RVX_ASSERT_NOW(a_commit_free, cmd.commit, !out_valid || out_ready)
  `RVX_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)
  `RVX_ASSERT_NOW(a_illegal_quiet, out_valid && status == rvx_pkg::ST_ILLEGAL,
    !wb_enable && mem_op == rvx_pkg::MEM_NONE)
  `RVX_ASSERT_NEXT(a_drain, out_valid && out_ready && !cmd.commit, !out_valid)

endmodule

[rtl/rvx_ram.sv]
module rvx_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr_a,
  input  logic [$clog2(Depth)-1:0] raddr_b,
  output logic [Width-1:0]         rdata_a,
  output logic [Width-1:0]         rdata_b
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

[rtl/rvx_ctrl.sv]
module rvx_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  rvx_pkg::dp_status_t st,
  output rvx_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_MUL,
    S_DIV
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        priority if (st.is_mul) begin
          cmd.mul_go = 1'b1;
          state_next = S_MUL;
        end else if (st.is_div) begin
          cmd.div_go = 1'b1;
          state_next = S_DIV;
        end else if (slot_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_MUL: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        if (!st.div_busy && slot_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/rvx_dp.sv]
module rvx_dp (
  input  logic                clk,
  input  logic                rst,
  input  rvx_pkg::ctrl_cmd_t  cmd,
  output rvx_pkg::dp_status_t st,
  input  logic                action,
  input  logic [31:0]         instr_word,
  input  logic [31:0]         load_word,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data,
  output logic [2:0]          status,
  output logic [31:0]         next_pc,
  output logic [1:0]          mem_op,
  output logic [31:0]         mem_addr,
  output logic [1:0]          mem_size,
  output logic [31:0]         store_data,
  output logic                wb_enable,
  output logic [4:0]          wb_index,
  output logic [31:0]         wb_value
);

  // captured beat
  logic        act_q;
  logic [31:0] ins;
  logic [31:0] ld;

  logic [31:0] pc;
  logic        pend;
  logic [4:0]  pend_rd;
  logic [2:0]  pend_kind;
  logic [31:0] vld;

  logic [31:0] rd1, rd2, a, b;
  logic [6:0]  op, f7;
  logic [2:0]  f3;
  logic [4:0]  rd, rs1, rs2;
  logic [31:0] immi, imms, immb, immj, immu;
  logic [4:0]  sh;
  logic [31:0] opb;

  // multiplier
  logic signed [65:0] prod;
  logic signed [32:0] ma, mb;

  // divider
  logic [31:0] quo, rem, dvs;
  logic [5:0]  cnt;
  logic [32:0] rem_sh, diff;
  logic        q_neg, r_neg, sgn;
  logic [31:0] ua, ub;

  // result
  rvx_pkg::status_t r_st;
  rvx_pkg::mem_op_t r_mop;
  logic [31:0] r_npc, r_addr, r_sd, r_wv;
  logic [1:0]  r_sz;
  logic        r_wr, bad, set_pend, clr_pend, pc_upd, take;
  logic [4:0]  r_idx;

  logic        ram_we;
  logic [4:0]  ram_waddr;
  logic [31:0] ram_wdata;

  rvx_ram #(.Width(32), .Depth(32)) u_regs (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (cmd.capture),
    .raddr_a (instr_word[19:15]),
    .raddr_b (instr_word[24:20]),
    .rdata_a (rd1),
    .rdata_b (rd2)
  );

  assign op   = ins[6:0];
  assign f3   = ins[14:12];
  assign f7   = ins[31:25];
  assign rd   = ins[11:7];
  assign rs1  = ins[19:15];
  assign rs2  = ins[24:20];
  assign a    = vld[rs1] ? rd1 : 32'd0;
  assign b    = vld[rs2] ? rd2 : 32'd0;
  assign immi = {{20{ins[31]}}, ins[31:20]};
  assign imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
  assign immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
  assign immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
  assign immu = {ins[31:12], 12'd0};
  assign opb  = (op == rvx_pkg::OPC_REG) ? b : immi;
  assign sh   = (op == rvx_pkg::OPC_REG) ? b[4:0] : ins[24:20];

  assign st.is_mul   = !act_q && !pend && op == rvx_pkg::OPC_REG
                       && f7 == rvx_pkg::F7_MULDIV && !f3[2];
  assign st.is_div   = !act_q && !pend && op == rvx_pkg::OPC_REG
                       && f7 == rvx_pkg::F7_MULDIV && f3[2];
  assign st.div_busy = (cnt != 6'd32);

  // mulh signs: mulh both, mulhsu a only
  assign ma = {(f3 == 3'd1 || f3 == 3'd2) & a[31], a};
  assign mb = {(f3 == 3'd1) & b[31], b};

  assign sgn   = !f3[0];
  assign q_neg = sgn && (a[31] ^ b[31]);
  assign r_neg = sgn && a[31];
  assign ua    = (sgn && a[31]) ? 32'd0 - a : a;
  assign ub    = (sgn && b[31]) ? 32'd0 - b : b;
  assign rem_sh = {rem, quo[31]};
  assign diff   = rem_sh - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      prod <= ma * mb;
    end
  end

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 6'd32;
    end else if (cmd.div_go) begin
      quo <= ua;
      rem <= 32'd0;
      dvs <= ub;
      cnt <= 6'd0;
    end else if (cnt != 6'd32) begin
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= rem_sh[31:0];
        quo <= {quo[30:0], 1'b0};
      end
      cnt <= cnt + 6'd1;
    end
  end

  always_comb begin
    r_st     = rvx_pkg::ST_OK;
    r_npc    = pc + 32'd4;
    r_mop    = rvx_pkg::MEM_NONE;
    r_addr   = 32'd0;
    r_sz     = 2'd0;
    r_sd     = 32'd0;
    r_wr     = 1'b0;
    r_idx    = rd;
    r_wv     = 32'd0;
    bad      = 1'b0;
    set_pend = 1'b0;
    clr_pend = 1'b0;
    pc_upd   = 1'b0;
    take     = 1'b0;
    if (act_q) begin
      r_npc = pc;
      if (!pend) begin
        r_st = rvx_pkg::ST_ORDER;
      end else begin
        unique case (pend_kind)
          3'd0:    r_wv = {{24{ld[7]}}, ld[7:0]};
          3'd1:    r_wv = {{16{ld[15]}}, ld[15:0]};
          3'd4:    r_wv = {24'd0, ld[7:0]};
          3'd5:    r_wv = {16'd0, ld[15:0]};
          default: r_wv = ld;
        endcase
        r_idx    = pend_rd;
        r_wr     = 1'b1;
        clr_pend = 1'b1;
      end
    end else if (pend) begin
      r_st  = rvx_pkg::ST_ORDER;
      r_npc = pc;
    end else begin
      pc_upd = 1'b1;
      unique case (op)
        rvx_pkg::OPC_LUI: begin
          r_wr = 1'b1;
          r_wv = immu;
        end
        rvx_pkg::OPC_AUIPC: begin
          r_wr = 1'b1;
          r_wv = immu + pc;
        end
        rvx_pkg::OPC_JAL: begin
          r_wr  = 1'b1;
          r_wv  = pc + 32'd4;
          r_npc = pc + immj;
        end
        rvx_pkg::OPC_JALR: begin
          if (f3 != 3'd0) begin
            bad = 1'b1;
          end else begin
            r_wr  = 1'b1;
            r_wv  = pc + 32'd4;
            r_npc = (a + immi) & ~32'd1;
          end
        end
        rvx_pkg::OPC_BRANCH: begin
          unique case (f3)
            3'd0:    take = (a == b);
            3'd1:    take = (a != b);
            3'd4:    take = ($signed(a) < $signed(b));
            3'd5:    take = ($signed(a) >= $signed(b));
            3'd6:    take = (a < b);
            3'd7:    take = (a >= b);
            default: bad = 1'b1;
          endcase
          if (take) begin
            r_npc = pc + immb;
          end
        end
        rvx_pkg::OPC_LOAD: begin
          if (f3 == 3'd3 || f3 > 3'd5) begin
            bad = 1'b1;
          end else begin
            r_mop    = rvx_pkg::MEM_LOAD;
            r_addr   = a + immi;
            r_sz     = f3[1:0];
            set_pend = 1'b1;
          end
        end
        rvx_pkg::OPC_STORE: begin
          if (f3 > 3'd2) begin
            bad = 1'b1;
          end else begin
            r_mop  = rvx_pkg::MEM_STORE;
            r_sz   = f3[1:0];
            r_sd   = b;
            r_addr = a + imms;
          end
        end
        rvx_pkg::OPC_IMM, rvx_pkg::OPC_REG: begin
          r_wr = 1'b1;
          if (op == rvx_pkg::OPC_REG && f7 == rvx_pkg::F7_MULDIV) begin
            priority if (!f3[2]) begin
              r_wv = (f3 == 3'd0) ? prod[31:0] : prod[63:32];
            end else if (!f3[1]) begin
              r_wv = (b == 32'd0) ? 32'hffff_ffff : (q_neg ? 32'd0 - quo : quo);
            end else begin
              r_wv = (b == 32'd0) ? a : (r_neg ? 32'd0 - rem : rem);
            end
          end else if (op == rvx_pkg::OPC_REG && f7 != rvx_pkg::F7_BASE
                       && !(f7 == rvx_pkg::F7_ALT && (f3 == 3'd0 || f3 == 3'd5))) begin
            bad = 1'b1;
          end else begin
            unique case (f3)
              3'd0: r_wv = (op == rvx_pkg::OPC_REG && f7 == rvx_pkg::F7_ALT)
                           ? a - opb : a + opb;
              3'd1: begin
                if (f7 != rvx_pkg::F7_BASE) bad = 1'b1;
                r_wv = a << sh;
              end
              3'd2: r_wv = {31'd0, $signed(a) < $signed(opb)};
              3'd3: r_wv = {31'd0, a < opb};
              3'd4: r_wv = a ^ opb;
              3'd5: begin
                priority if (f7 == rvx_pkg::F7_BASE) begin
                  r_wv = a >> sh;
                end else if (f7 == rvx_pkg::F7_ALT) begin
                  r_wv = $unsigned($signed(a) >>> sh);
                end else begin
                  bad = 1'b1;
                end
              end
              3'd6: r_wv = a | opb;
              default: r_wv = a & opb;
            endcase
          end
        end
        rvx_pkg::OPC_FENCE: ;
        rvx_pkg::OPC_SYSTEM: begin
          priority if (ins == rvx_pkg::WORD_ECALL) begin
            r_st = rvx_pkg::ST_ECALL;
          end else if (ins == rvx_pkg::WORD_EBREAK) begin
            r_st  = rvx_pkg::ST_EBREAK;
            r_npc = pc;
          end else begin
            bad = 1'b1;
          end
        end
        default: bad = 1'b1;
      endcase
      if (bad) begin
        r_st     = rvx_pkg::ST_ILLEGAL;
        r_npc    = pc;
        r_wr     = 1'b0;
        r_mop    = rvx_pkg::MEM_NONE;
        r_addr   = 32'd0;
        r_sz     = 2'd0;
        r_sd     = 32'd0;
        set_pend = 1'b0;
      end
    end
    if (!r_wr || r_idx == 5'd0) begin
      r_wr  = 1'b0;
      r_idx = 5'd0;
      r_wv  = 32'd0;
    end
  end

  // the user sends config writes only while idle; not enforced here
  always_comb begin
    if (cfg_we && cfg_index == rvx_pkg::CFG_STACK) begin
      ram_we    = 1'b1;
      ram_waddr = 5'd2;
      ram_wdata = cfg_data;
    end else begin
      ram_we    = cmd.commit && r_wr;
      ram_waddr = r_idx;
      ram_wdata = r_wv;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q <= action;
      ins   <= instr_word;
      ld    <= load_word;
    end
    if (cmd.commit) begin
      status     <= r_st;
      next_pc    <= r_npc;
      mem_op     <= r_mop;
      mem_addr   <= r_addr;
      mem_size   <= r_sz;
      store_data <= r_sd;
      wb_enable  <= r_wr;
      wb_index   <= r_idx;
      wb_value   <= r_wv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= 32'd0;
      pend      <= 1'b0;
      pend_rd   <= 5'd0;
      pend_kind <= 3'd0;
      vld       <= 32'd0;
    end else begin
      if (cfg_we && cfg_index == rvx_pkg::CFG_START_PC) begin
        pc <= cfg_data;
      end else if (cmd.commit && pc_upd) begin
        pc <= r_npc;
      end
      if (ram_we) begin
        vld[ram_waddr] <= 1'b1;
      end
      if (cmd.commit && set_pend) begin
        pend      <= 1'b1;
        pend_rd   <= rd;
        pend_kind <= f3;
      end else if (cmd.commit && clr_pend) begin
        pend <= 1'b0;
      end
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  typedef struct packed {
    logic [2:0]  st;
    logic [31:0] npc;
    logic [1:0]  mop;
    logic [31:0] maddr;
    logic [1:0]  msize;
    logic [31:0] sdata;
    logic        wen;
    logic [4:0]  widx;
    logic [31:0] wval;
  } retire_t;

  int unsigned fails = 0;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  class rv_scoreboard;
    logic [31:0] regs [32];
    logic [31:0] pc;
    logic        ld_wait;
    logic [4:0]  ld_dest;
    logic [2:0]  ld_kind;
    retire_t     pending_q[$];

    function void clear();
      foreach (regs[i]) regs[i] = '0;
      pc = '0; ld_wait = 0; ld_dest = '0; ld_kind = '0;
    endfunction

    function void set_reg(logic idx, logic [31:0] v);
      if (idx == rvx_pkg::CFG_START_PC) pc = v;
      else regs[2] = v;
    endfunction

    function retire_t execute(logic act, logic [31:0] ins, logic [31:0] ld);
      retire_t r;
      logic [6:0] op, f7;
      logic [2:0] f3;
      logic [31:0] a, b, immi, wv, imm;
      logic [4:0] rd, sh;
      logic wr, bad, take;
      logic signed [63:0] sa, sb, prod;
      logic [63:0] up;
      r = '0; wr = 0; wv = '0; bad = 0; take = 0;
      rd = ins[11:7]; r.npc = pc + 4;
      if (act) begin
        r.npc = pc;
        if (!ld_wait) r.st = rvx_pkg::ST_ORDER;
        else begin
          case (ld_kind)
            3'd0: wv = {{24{ld[7]}}, ld[7:0]};
            3'd1: wv = {{16{ld[15]}}, ld[15:0]};
            3'd4: wv = {24'b0, ld[7:0]};
            3'd5: wv = {16'b0, ld[15:0]};
            default: wv = ld;
          endcase
          rd = ld_dest; wr = 1; ld_wait = 0;
        end
      end else if (ld_wait) begin
        r.st = rvx_pkg::ST_ORDER; r.npc = pc;
      end else begin
        op = ins[6:0]; f3 = ins[14:12]; f7 = ins[31:25];
        a = regs[ins[19:15]]; b = regs[ins[24:20]];
        immi = {{20{ins[31]}}, ins[31:20]};
        sa = $signed(a); sb = $signed(b);
        case (op)
          rvx_pkg::OPC_LUI: begin wr = 1; wv = {ins[31:12], 12'b0}; end
          rvx_pkg::OPC_AUIPC: begin wr = 1; wv = {ins[31:12], 12'b0} + pc; end
          rvx_pkg::OPC_JAL: begin
            imm = {{12{ins[31]}}, ins[19:12], ins[20], ins[30:21], 1'b0};
            wr = 1; wv = pc + 4; r.npc = pc + imm;
          end
          rvx_pkg::OPC_JALR:
            if (f3 != 0) bad = 1;
            else begin wr = 1; wv = pc + 4; r.npc = (a + immi) & ~32'd1; end
          rvx_pkg::OPC_BRANCH: begin
            imm = {{20{ins[31]}}, ins[7], ins[30:25], ins[11:8], 1'b0};
            case (f3)
              3'd0: take = a == b;
              3'd1: take = a != b;
              3'd4: take = $signed(a) < $signed(b);
              3'd5: take = $signed(a) >= $signed(b);
              3'd6: take = a < b;
              3'd7: take = a >= b;
              default: bad = 1;
            endcase
            if (take) r.npc = pc + imm;
          end
          rvx_pkg::OPC_LOAD:
            if (f3 == 3 || f3 > 5) bad = 1;
            else begin
              r.mop = rvx_pkg::MEM_LOAD; r.maddr = a + immi; r.msize = f3[1:0];
              ld_wait = 1; ld_dest = rd; ld_kind = f3;
            end
          rvx_pkg::OPC_STORE:
            if (f3 > 2) bad = 1;
            else begin
              r.mop = rvx_pkg::MEM_STORE; r.msize = f3[1:0]; r.sdata = b;
              r.maddr = a + {{20{ins[31]}}, ins[31:25], ins[11:7]};
            end
          rvx_pkg::OPC_IMM: begin
            sh = ins[24:20]; wr = 1;
            case (f3)
              3'd0: wv = a + immi;
              3'd1: if (f7 != rvx_pkg::F7_BASE) bad = 1; else wv = a << sh;
              3'd2: wv = ($signed(a) < $signed(immi)) ? 1 : 0;
              3'd3: wv = (a < immi) ? 1 : 0;
              3'd4: wv = a ^ immi;
              3'd5:
                if (f7 == rvx_pkg::F7_BASE) wv = a >> sh;
                else if (f7 == rvx_pkg::F7_ALT) wv = $signed(a) >>> sh;
                else bad = 1;
              3'd6: wv = a | immi;
              default: wv = a & immi;
            endcase
          end
          rvx_pkg::OPC_REG: begin
            sh = b[4:0]; wr = 1;
            if (f7 == rvx_pkg::F7_BASE) begin
              case (f3)
                3'd0: wv = a + b;
                3'd1: wv = a << sh;
                3'd2: wv = ($signed(a) < $signed(b)) ? 1 : 0;
                3'd3: wv = (a < b) ? 1 : 0;
                3'd4: wv = a ^ b;
                3'd5: wv = a >> sh;
                3'd6: wv = a | b;
                default: wv = a & b;
              endcase
            end else if (f7 == rvx_pkg::F7_ALT) begin
              if (f3 == 0) wv = a - b;
              else if (f3 == 5) wv = $signed(a) >>> sh;
              else bad = 1;
            end else if (f7 == rvx_pkg::F7_MULDIV) begin
              case (f3)
                3'd0: wv = a * b;
                3'd1: begin prod = sa * sb; wv = prod[63:32]; end
                3'd2: begin prod = sa * $signed({32'b0, b}); wv = prod[63:32]; end
                3'd3: begin up = {32'b0, a} * {32'b0, b}; wv = up[63:32]; end
                3'd4:
                  if (b == 0) wv = '1;
                  else if (a == 32'h8000_0000 && b == '1) wv = a;
                  else begin prod = sa / sb; wv = prod[31:0]; end
                3'd5: wv = (b == 0) ? '1 : a / b;
                3'd6:
                  if (b == 0) wv = a;
                  else if (a == 32'h8000_0000 && b == '1) wv = 0;
                  else begin prod = sa % sb; wv = prod[31:0]; end
                default: wv = (b == 0) ? a : a % b;
              endcase
            end else bad = 1;
          end
          rvx_pkg::OPC_FENCE: ;
          rvx_pkg::OPC_SYSTEM:
            if (ins == rvx_pkg::WORD_ECALL) r.st = rvx_pkg::ST_ECALL;
            else if (ins == rvx_pkg::WORD_EBREAK) begin
              r.st = rvx_pkg::ST_EBREAK; r.npc = pc;
            end
            else bad = 1;
          default: bad = 1;
        endcase
        if (bad) begin
          r.st = rvx_pkg::ST_ILLEGAL; r.npc = pc; wr = 0;
          r.mop = rvx_pkg::MEM_NONE; r.maddr = 0; r.msize = 0; r.sdata = 0;
        end
        pc = r.npc;
      end
      if (wr && rd != 0) begin
        regs[rd] = wv; r.wen = 1; r.widx = rd; r.wval = wv;
      end
      return r;
    endfunction

    function void note_beat(logic act, logic [31:0] ins, logic [31:0] ld);
      pending_q.push_back(execute(act, ins, ld));
    endfunction

    task check_result(retire_t got);
      retire_t w;
      if (pending_q.size() == 0) begin
        report("unexpected result", got.npc, 0);
        return;
      end
      w = pending_q.pop_front();
      if (got.st !== w.st) report("status", got.st, w.st);
      if (got.npc !== w.npc) report("next_pc", got.npc, w.npc);
      if (got.mop !== w.mop) report("mem_op", got.mop, w.mop);
      if (got.maddr !== w.maddr) report("mem_addr", got.maddr, w.maddr);
      if (got.msize !== w.msize) report("mem_size", got.msize, w.msize);
      if (got.sdata !== w.sdata) report("store_data", got.sdata, w.sdata);
      if (got.wen !== w.wen) report("wb_enable", got.wen, w.wen);
      if (got.widx !== w.widx) report("wb_index", got.widx, w.widx);
      if (got.wval !== w.wval) report("wb_value", got.wval, w.wval);
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, action = 0, out_ready = 0;
  logic [31:0] instr_word = 0, load_word = 0, cfg_data = 0;
  logic cfg_we = 0, cfg_index = 0;
  logic in_ready, out_valid, wb_enable;
  logic [2:0] status;
  logic [31:0] next_pc, mem_addr, store_data, wb_value;
  logic [1:0] mem_op, mem_size;
  logic [4:0] wb_index;
  logic calm = 0, hold_off = 0;
  int idle_left = 0;

  rv_scoreboard exec_sb = new();

  rv32im_execute_core u_top (.*);

  initial forever #2 clk = ~clk;

  initial begin
    #20ms;
    $display("tb_top: FAIL");
    $finish;
  end

  // receiver: short idle bursts, one long hold-off
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      exec_sb.check_result('{status, next_pc, mem_op, mem_addr, mem_size, store_data,
                             wb_enable, wb_index, wb_value});
    if (rst || hold_off) out_ready <= 0;
    else if (calm) out_ready <= 1;
    else if (idle_left != 0) begin
      out_ready <= 0;
      idle_left <= idle_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= 0;
      idle_left <= $urandom_range(0, 2);
    end else out_ready <= 1;
  end

  task automatic send(logic act, logic [31:0] ins, logic [31:0] ld);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; action <= act; instr_word <= ins; load_word <= ld;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    exec_sb.note_beat(act, ins, ld);
  endtask

  task automatic write_cfg(logic idx, logic [31:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    exec_sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (exec_sb.pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic logic [31:0] r_type(logic [6:0] f7, logic [2:0] f3);
    return {f7, 5'($urandom), 5'($urandom), f3, 5'($urandom), rvx_pkg::OPC_REG};
  endfunction

  // mostly legal words with random fields; a few pure noise words
  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 11))
      0: w[6:0] = rvx_pkg::OPC_LUI;
      1: w[6:0] = rvx_pkg::OPC_AUIPC;
      2: w[6:0] = rvx_pkg::OPC_JAL;
      3: begin
        w[6:0] = rvx_pkg::OPC_JALR;
        w[14:12] = ($urandom_range(0, 5) == 0) ? w[14:12] : 3'd0;
      end
      4: w[6:0] = rvx_pkg::OPC_BRANCH;
      5: w[6:0] = rvx_pkg::OPC_LOAD;
      6: w[6:0] = rvx_pkg::OPC_STORE;
      7: begin
        w[6:0] = rvx_pkg::OPC_IMM;
        if ($urandom_range(0, 3) != 0)
          w[31:25] = $urandom_range(0, 1) ? rvx_pkg::F7_ALT : rvx_pkg::F7_BASE;
      end
      8, 9: begin
        w[6:0] = rvx_pkg::OPC_REG;
        case ($urandom_range(0, 6))
          0: w[31:25] = w[31:25];
          1, 2: w[31:25] = rvx_pkg::F7_BASE;
          3: w[31:25] = rvx_pkg::F7_ALT;
          default: w[31:25] = rvx_pkg::F7_MULDIV;
        endcase
      end
      10: w[6:0] = ($urandom_range(0, 1)) ? rvx_pkg::OPC_FENCE : rvx_pkg::OPC_SYSTEM;
      default: ;
    endcase
    return w;
  endfunction

  int n;
  int unsigned k;
  initial begin
    exec_sb.clear();
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    write_cfg(rvx_pkg::CFG_START_PC, 32'h0000_1000);
    write_cfg(rvx_pkg::CFG_STACK, 32'h8000_0000);
    // directed: corner operands and special cases
    send(0, {12'hfff, 5'd0, 3'd0, 5'd1, rvx_pkg::OPC_IMM}, 0);       // x1 = -1
    send(0, {20'h80000, 5'd3, rvx_pkg::OPC_LUI}, 0);                // x3 = min int
    send(0, {rvx_pkg::F7_MULDIV, 5'd1, 5'd3, 3'd4, 5'd4, rvx_pkg::OPC_REG}, 0); // div overflow
    send(0, {rvx_pkg::F7_MULDIV, 5'd1, 5'd3, 3'd6, 5'd4, rvx_pkg::OPC_REG}, 0); // rem overflow
    send(0, {rvx_pkg::F7_MULDIV, 5'd0, 5'd1, 3'd5, 5'd5, rvx_pkg::OPC_REG}, 0); // by zero
    send(0, {rvx_pkg::F7_MULDIV, 5'd0, 5'd3, 3'd7, 5'd5, rvx_pkg::OPC_REG}, 0);
    send(0, {rvx_pkg::F7_MULDIV, 5'd1, 5'd3, 3'd1, 5'd6, rvx_pkg::OPC_REG}, 0);
    send(0, {rvx_pkg::F7_MULDIV, 5'd1, 5'd3, 3'd2, 5'd6, rvx_pkg::OPC_REG}, 0);
    send(0, {rvx_pkg::F7_MULDIV, 5'd1, 5'd1, 3'd3, 5'd6, rvx_pkg::OPC_REG}, 0);
    send(0, {rvx_pkg::F7_ALT, 5'd1, 5'd3, 3'd5, 5'd7, rvx_pkg::OPC_REG}, 0);
    send(0, {12'hfff, 5'd2, 3'd0, 5'd0, rvx_pkg::OPC_IMM}, 0);       // write to x0
    send(0, {12'h010, 5'd2, 3'd0, 5'd0, rvx_pkg::OPC_LOAD}, 0);      // load into x0
    send(0, 0, 0);                                                 // out of order
    send(1, 0, 32'hdead_beef);
    send(1, 0, 32'h1234_5678);                                     // none pending
    send(0, {12'hffc, 5'd2, 3'd4, 5'd8, rvx_pkg::OPC_LOAD}, 0);
    send(1, 0, 32'hffff_ff80);
    send(0, rvx_pkg::WORD_ECALL, 0);
    send(0, rvx_pkg::WORD_EBREAK, 0);
    send(0, 32'h0020_0073, 0);                                     // other system word
    send(0, 32'hffff_ffff, 0);                                     // unknown opcode
    send(0, {12'h0, 5'd1, 3'd1, 5'd9, rvx_pkg::OPC_JALR}, 0);        // bad jalr
    send(0, {7'h7f, 5'd1, 5'd3, 3'd0, 5'd9, rvx_pkg::OPC_STORE}, 0);
    send(0, {1'b1, 10'h3ff, 1'b1, 8'hff, 5'd10, rvx_pkg::OPC_JAL}, 0);
    send(0, {12'h0, 5'd1, 3'd0, 5'd11, rvx_pkg::OPC_JALR}, 0);
    // long receiver hold-off while beats keep coming
    fork
      begin hold_off = 1; repeat (300) @(posedge clk); hold_off = 0; end
      for (k = 0; k < 6; k++) send(0, r_type(rvx_pkg::F7_BASE, 3'($urandom)), 0);
    join
    drain();
    for (n = 0; n < 4; n++) begin
      case (n)
        0: begin
          write_cfg(rvx_pkg::CFG_START_PC, '1);
          write_cfg(rvx_pkg::CFG_STACK, '1);
        end
        1: begin
          write_cfg(rvx_pkg::CFG_START_PC, 0);
          write_cfg(rvx_pkg::CFG_STACK, 0);
        end
        default: begin
          write_cfg(rvx_pkg::CFG_START_PC, $urandom);
          write_cfg(rvx_pkg::CFG_STACK, $urandom);
        end
      endcase
      if (n == 3) calm = 1;
      for (k = 0; k < 200; k++) begin
        if ($urandom_range(0, 30) == 0) send(1, 0, $urandom);
        else begin
          send(0, rand_word(), 0);
          if (exec_sb.ld_wait && $urandom_range(0, 9) != 0) send(1, 0, $urandom);
        end
      end
      drain();
    end
    if (fails == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end
endmodule
